@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the run-length decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/brle_pkg.sv @@
// Shared types, register indexes and defaults of the run-length decoder.
package brle_pkg;

	// Default size limits
	localparam int MAX_COLUMNS_DEF = 4096;
	localparam int MAX_ROWS_DEF    = 4096;

	// Depth of the byte queue and the run queue
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam logic [2:0] REG_COLUMNS    = 3'd0;
	localparam logic [2:0] REG_ROWS       = 3'd1;
	localparam logic [2:0] REG_START_MODE = 3'd2;
	localparam logic [2:0] REG_HIGH_VALUE = 3'd3;
	localparam logic [2:0] REG_LOW_VALUE  = 3'd4;

	// Start mode where every row carries its own color bit
	localparam logic [1:0] MODE_COLOR_BIT = 2'd0;

	// Register reset values
	localparam logic [12:0] COLUMNS_RST    = 13'd512;
	localparam logic [12:0] ROWS_RST       = 13'd512;
	localparam logic [1:0]  START_MODE_RST = 2'd0;
	localparam logic [7:0]  HIGH_VALUE_RST = 8'd255;
	localparam logic [7:0]  LOW_VALUE_RST  = 8'd0;

	typedef struct packed {
		logic [12:0] columns;
		logic [12:0] rows;
		logic [1:0]  start_mode;
		logic [7:0]  high_value;
		logic [7:0]  low_value;
	} cfg_t;

	// One decoded run
	typedef struct packed {
		logic        last;
		logic        frame_end;
		logic        row_end;
		logic [12:0] run_length;
		logic [7:0]  pixel_value;
	} run_t;

endpackage

@@ design/brle_fifo.sv @@
// Small synchronous queue used between the decoder stages.
module brle_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (count_q != NW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + NW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

@@ design/brle_core.sv @@
// Bit-serial back end: walks each code byte one bit a cycle unless the output stalls, and builds runs.
module brle_core #(
	parameter int MAX_COLUMNS = brle_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = brle_pkg::MAX_ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  brle_pkg::cfg_t    cfg,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  logic [7:0]        byte_data,
	output logic              run_valid,
	input  logic              run_ready,
	output brle_pkg::run_t    run_data
);

	localparam int AW = $clog2(MAX_COLUMNS);
	localparam int CW = AW + 1;
	localparam int BW = $clog2(AW + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);

	// Bit length of x, at least one
	function automatic logic [BW-1:0] bit_len(input logic [CW-1:0] x);
		logic [BW-1:0] n;
		n = BW'(1);
		for (int i = 1; i < AW; i++) begin
			if (x[i]) begin
				n = BW'(i + 1);
			end
		end
		return n;
	endfunction

	// Decoder state
	logic [2:0]    bit_idx_q;
	logic          need_color_q;
	logic          color_q;
	logic [CW-1:0] cols_left_q;
	logic [BW-1:0] code_bits_q;
	logic [AW-1:0] accum_q;
	logic [RW-1:0] row_q;

	// Run held back until it is known whether it is the byte's last one
	brle_pkg::run_t pend_q;
	logic           pend_v_q;
	logic           flush_q;

	logic [CW-1:0] eff_cols;
	logic [RW-1:0] eff_rows;
	logic          cur_bit;
	logic          color_bit_only;
	logic [CW-1:0] cols_cur;
	logic          color_cur;
	logic          new_code;
	logic [BW-1:0] bits_cur;
	logic [BW-1:0] bits_nxt;
	logic [AW-1:0] accum_cur;
	logic [AW-1:0] accum_nxt;
	logic          run_hit;
	logic [CW-1:0] len_raw;
	logic [CW-1:0] len;
	logic [CW-1:0] cols_new;
	logic          row_done;
	logic [RW:0]   row_inc;
	logic          frame_hit;
	logic          byte_end;
	logic          need_push;
	logic          push_last;
	logic          advance;
	logic          step;
	brle_pkg::run_t new_run;

	// Clamp the size registers into range
	always_comb begin
		if (cfg.columns == '0) begin
			eff_cols = CW'(1);
		end else if (32'(cfg.columns) > 32'(MAX_COLUMNS)) begin
			eff_cols = CW'(MAX_COLUMNS);
		end else begin
			eff_cols = CW'(cfg.columns);
		end
		if (cfg.rows == '0) begin
			eff_rows = RW'(1);
		end else if (32'(cfg.rows) > 32'(MAX_ROWS)) begin
			eff_rows = RW'(MAX_ROWS);
		end else begin
			eff_rows = RW'(cfg.rows);
		end
	end

	// One code bit
	always_comb begin
		cur_bit        = byte_data[bit_idx_q];
		color_bit_only = need_color_q && (cfg.start_mode == brle_pkg::MODE_COLOR_BIT);
		cols_cur       = need_color_q ? eff_cols : cols_left_q;
		color_cur      = need_color_q ? cfg.start_mode[1] : color_q;
		new_code       = need_color_q || (code_bits_q == '0);
		bits_cur       = new_code ? bit_len(cols_cur - CW'(1)) : code_bits_q;
		accum_cur      = new_code ? '0 : accum_q;
		accum_nxt      = AW'({accum_cur, cur_bit});
		bits_nxt       = bits_cur - BW'(1);
		run_hit        = !color_bit_only && (bits_nxt == '0);
		len_raw        = CW'(accum_nxt) + CW'(1);
		len            = (len_raw > cols_cur) ? cols_cur : len_raw;
		cols_new       = cols_cur - len;
		row_done       = run_hit && (cols_new == '0);
		row_inc        = {1'b0, row_q} + (RW + 1)'(1);
		frame_hit      = row_done && (row_inc >= {1'b0, eff_rows});
		byte_end       = (bit_idx_q == 3'd0) || frame_hit;

		new_run.pixel_value = color_cur ? cfg.high_value : cfg.low_value;
		new_run.run_length  = 13'(len);
		new_run.row_end     = row_done;
		new_run.frame_end   = frame_hit;
		new_run.last        = 1'b0;
	end

	// Output push and stall
	always_comb begin
		need_push = flush_q
			|| (byte_valid && run_hit && pend_v_q)
			|| (byte_valid && byte_end && !run_hit && pend_v_q);
		push_last = flush_q || (byte_end && !run_hit);
		advance   = !need_push || run_ready;
		step      = byte_valid && advance;

		run_valid     = need_push;
		run_data      = pend_q;
		run_data.last = push_last;
		byte_ready    = step && byte_end;
	end

	// Decoder state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_idx_q    <= 3'd7;
			need_color_q <= 1'b1;
			color_q      <= 1'b0;
			cols_left_q  <= '0;
			code_bits_q  <= '0;
			accum_q      <= '0;
			row_q        <= '0;
		end else if (step) begin
			bit_idx_q <= byte_end ? 3'd7 : bit_idx_q - 3'd1;
			if (color_bit_only) begin
				need_color_q <= 1'b0;
				color_q      <= cur_bit;
				cols_left_q  <= eff_cols;
				code_bits_q  <= '0;
				accum_q      <= '0;
			end else if (run_hit) begin
				need_color_q <= row_done;
				color_q      <= ~color_cur;
				cols_left_q  <= cols_new;
				code_bits_q  <= '0;
				accum_q      <= '0;
				if (row_done) begin
					row_q <= frame_hit ? '0 : RW'(row_inc);
				end
			end else begin
				need_color_q <= 1'b0;
				color_q      <= color_cur;
				cols_left_q  <= cols_cur;
				code_bits_q  <= bits_nxt;
				accum_q      <= accum_nxt;
			end
		end
	end

	// Held run and end-of-byte flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			flush_q  <= 1'b0;
		end else begin
			if (step && run_hit) begin
				pend_v_q <= 1'b1;
			end else if (need_push && advance) begin
				pend_v_q <= 1'b0;
			end
			if (step && run_hit && byte_end) begin
				flush_q <= 1'b1;
			end else if (need_push && advance) begin
				flush_q <= 1'b0;
			end
		end
	end

	// Run payload
	always_ff @(posedge clk) begin
		if (step && run_hit) begin
			pend_q <= new_run;
		end
	end

endmodule

@@ design/binary_rle_row_decoder_top.sv @@
// Top level of the run-length decoder for two-level image rows.
//
// Code bytes arrive on s_axis (tdata[7:0]) and are read most significant bit
// first. Decoded runs leave on m_axis: tdata holds the pixel value and the run
// length, tuser the row and frame end marks, tlast marks the final run that a
// byte produced. Registers are to be written on the cfg channel (always ready)
// only while the decoder is idle; the block itself does not enforce this.
// A two-entry byte queue feeds a bit-serial decoder that handles one code bit
// per cycle unless the output stalls. When a byte ends a frame, the rest of
// that byte is dropped. Runs pass through a held-run register and a two-entry
// run queue. Reset sets the registers to their defaults and starts at the first
// row of a frame. When the receiver stalls, the run queue fills, the decoder
// holds its bit position, the byte queue fills and s_axis_tready drops.
module binary_rle_row_decoder_top #(
	parameter int MAX_COLUMNS = brle_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = brle_pkg::MAX_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	// Code bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
	// Decoded runs
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] pixel_value, [20:8] run_length, [23:21] zero
	output logic [1:0]  m_axis_tuser,   // [0] row_end, [1] frame_end
	output logic        m_axis_tlast
);

	localparam int RUN_W = $bits(brle_pkg::run_t);

	brle_pkg::cfg_t cfg_q;

	logic             byte_valid;
	logic             byte_ready;
	logic [7:0]       byte_data;
	logic             run_valid;
	logic             run_ready;
	brle_pkg::run_t   run_data;
	logic [RUN_W-1:0] out_bits;
	brle_pkg::run_t   out_run;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.columns    <= brle_pkg::COLUMNS_RST;
			cfg_q.rows       <= brle_pkg::ROWS_RST;
			cfg_q.start_mode <= brle_pkg::START_MODE_RST;
			cfg_q.high_value <= brle_pkg::HIGH_VALUE_RST;
			cfg_q.low_value  <= brle_pkg::LOW_VALUE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				brle_pkg::REG_COLUMNS:    cfg_q.columns    <= cfg_data;
				brle_pkg::REG_ROWS:       cfg_q.rows       <= cfg_data;
				brle_pkg::REG_START_MODE: cfg_q.start_mode <= cfg_data[1:0];
				brle_pkg::REG_HIGH_VALUE: cfg_q.high_value <= cfg_data[7:0];
				brle_pkg::REG_LOW_VALUE:  cfg_q.low_value  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Front: byte queue
	brle_fifo #(
		.WIDTH(8),
		.DEPTH(brle_pkg::QUEUE_DEPTH)
	) u_byte_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(s_axis_tvalid),
		.wr_ready(s_axis_tready),
		.wr_data (s_axis_tdata),
		.rd_valid(byte_valid),
		.rd_ready(byte_ready),
		.rd_data (byte_data)
	);

	// Back: bit-serial decoder
	brle_core #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data (byte_data),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run_data  (run_data)
	);

	// Run queue toward the output
	brle_fifo #(
		.WIDTH(RUN_W),
		.DEPTH(brle_pkg::QUEUE_DEPTH)
	) u_run_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(run_valid),
		.wr_ready(run_ready),
		.wr_data (run_data),
		.rd_valid(m_axis_tvalid),
		.rd_ready(m_axis_tready),
		.rd_data (out_bits)
	);

	assign out_run      = out_bits;
	assign m_axis_tdata = {3'b000, out_run.run_length, out_run.pixel_value};
	assign m_axis_tuser = {out_run.frame_end, out_run.row_end};
	assign m_axis_tlast = out_run.last;

endmodule

@@ design/brle_checker.sv @@
// Port-level checks of the run-length decoder, bound to its top level.
`include "assert_macros.svh"

module brle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// A frame end is always also a row end
	`ASSERT_IMPL(frame_implies_row, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "frame end without row end")

	// The rest of a byte is dropped at frame end, so that run closes the byte
	`ASSERT_IMPL(frame_implies_last, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "frame end run not marked last")

	// Every run covers at least one pixel
	`ASSERT_IMPL(run_nonzero, clk, arst_n, m_axis_tvalid, m_axis_tdata[20:8] != 13'd0, "zero-length run")

	// A stalled run holds until its transfer
	`ASSERT_NEXT(out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled run changed")

endmodule

bind binary_rle_row_decoder_top brle_checker u_brle_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

@@ sim/binary_rle_row_decoder_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the run-length row decoder: directed and random code bytes.
module binary_rle_row_decoder_top_tb;

	localparam int MAX_COLS = brle_pkg::MAX_COLUMNS_DEF;
	localparam int MAX_ROWS = brle_pkg::MAX_ROWS_DEF;
	localparam logic [1:0] MODE_START_LOW  = 2'd1;
	localparam logic [1:0] MODE_START_HIGH = 2'd2;
	localparam logic [1:0] MODE_START_ALT  = 2'd3;
	// byte queue (2) bytes walked bit by bit, plus pipeline, with margin
	localparam int DRAIN_CYCLES   = 48;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 220;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// transfer flags of the last rising edge, read by the falling-edge drivers
	logic s_fire = 1'b0;
	logic cfg_fire = 1'b0;

	logic [7:0]     code_bytes_pending[$];
	brle_pkg::run_t runs_due[$];

	// shadow registers and decoder state
	logic [12:0] cfg_columns;
	logic [12:0] cfg_rows;
	logic [1:0]  cfg_mode;
	logic [7:0]  cfg_high;
	logic [7:0]  cfg_low;
	logic        need_color;
	logic        cur_color;
	int          cols_left;
	int          code_left;
	int          code_val;
	int          row_count;

	int  fail_count = 0;
	int  quiet_cycles = 0;
	int  random_items = 0;
	bit  tx_steady = 1'b0;
	bit  rx_steady = 1'b1;
	int  burst_left = 0;
	int  gap_left = 0;
	int  rx_left = 0;

	always #2 clk = ~clk;

	binary_rle_row_decoder_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	function automatic int eff_columns();
		if (cfg_columns == 13'd0) return 1;
		if (int'(cfg_columns) > MAX_COLS) return MAX_COLS;
		return int'(cfg_columns);
	endfunction

	function automatic int eff_rows();
		if (cfg_rows == 13'd0) return 1;
		if (int'(cfg_rows) > MAX_ROWS) return MAX_ROWS;
		return int'(cfg_rows);
	endfunction

	// bits needed for x, never less than one
	function automatic int code_width(input int x);
		int n;
		n = 1;
		while (n < 32 && (x >> n) != 0) n++;
		return n;
	endfunction

	function automatic void apply_cfg(input logic [2:0] idx, input logic [12:0] data);
		case (idx)
			brle_pkg::REG_COLUMNS: begin
				cfg_columns = data;
			end
			brle_pkg::REG_ROWS: begin
				cfg_rows = data;
			end
			brle_pkg::REG_START_MODE: begin
				cfg_mode = data[1:0];
			end
			brle_pkg::REG_HIGH_VALUE: begin
				cfg_high = data[7:0];
			end
			brle_pkg::REG_LOW_VALUE: begin
				cfg_low = data[7:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Walk the byte MSB first and queue every run it completes
	function automatic void decode_byte(input logic [7:0] code);
		int             i;
		int             len;
		logic           b;
		logic           frame_done;
		brle_pkg::run_t r;
		brle_pkg::run_t made[$];
		for (i = 7; i >= 0; i--) begin
			b = code[i];
			if (need_color) begin
				// row start samples columns and start mode
				need_color = 1'b0;
				cols_left  = eff_columns();
				code_left  = 0;
				code_val   = 0;
				if (cfg_mode == brle_pkg::MODE_COLOR_BIT) begin
					cur_color = b;
					continue;
				end
				cur_color = cfg_mode[1];
			end
			if (code_left == 0) begin
				code_left = code_width(cols_left - 1);
				code_val  = 0;
			end
			code_val = (code_val << 1) | int'(b);
			code_left--;
			if (code_left == 0) begin
				len = code_val + 1;
				// overlong run is clipped to the rest of the row
				if (len > cols_left) len = cols_left;
				cols_left -= len;
				r.pixel_value = cur_color ? cfg_high : cfg_low;
				r.run_length  = 13'(len);
				r.row_end     = (cols_left == 0);
				r.last        = 1'b0;
				frame_done    = 1'b0;
				cur_color     = ~cur_color;
				code_val      = 0;
				if (r.row_end) begin
					need_color = 1'b1;
					row_count++;
					if (row_count >= eff_rows()) begin
						row_count  = 0;
						frame_done = 1'b1;
					end
				end
				r.frame_end = frame_done;
				made.push_back(r);
				// rest of the byte is dropped at frame end
				if (frame_done) break;
			end
		end
		if (made.size() != 0) made[made.size() - 1].last = 1'b1;
		foreach (made[k]) runs_due.push_back(made[k]);
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	task automatic check_run();
		brle_pkg::run_t want;
		if (runs_due.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected run, expected none, got tdata %h tuser %b tlast %b",
				$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end else begin
			want = runs_due.pop_front();
			check_field("pixel_value", want.pixel_value, m_axis_tdata[7:0]);
			check_field("run_length", want.run_length, m_axis_tdata[20:8]);
			check_field("row_end", want.row_end, m_axis_tuser[0]);
			check_field("frame_end", want.frame_end, m_axis_tuser[1]);
			check_field("last", want.last, m_axis_tlast);
		end
	endtask

	// Prediction, checking and watchdog on the rising edge
	always @(posedge clk) begin
		s_fire   <= s_axis_tvalid && s_axis_tready;
		cfg_fire <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) check_run();
			if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
					|| (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("FAIL binary_rle_row_decoder_top");
				$finish;
			end
		end
	end

	// Byte driver: bursts with random gaps, or steady
	always @(negedge clk) begin
		if (!s_axis_tvalid || s_fire) begin
			if (gap_left != 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (code_bytes_pending.size() != 0) begin
				s_axis_tdata  <= code_bytes_pending.pop_front();
				s_axis_tvalid <= 1'b1;
				if (!tx_steady) begin
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Run receiver: alternating ready and stall stretches, or always ready
	always @(negedge clk) begin
		if (rx_steady) begin
			m_axis_tready <= 1'b1;
		end else if (rx_left == 0) begin
			if (m_axis_tready) begin
				m_axis_tready <= 1'b0;
				rx_left = $urandom_range(0, 9);
			end else begin
				m_axis_tready <= 1'b1;
				rx_left = $urandom_range(0, 11);
			end
		end else begin
			rx_left--;
		end
	end

	task automatic wr_reg(input logic [2:0] idx, input logic [12:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid <= 1'b0;
	endtask

	// Wait until all bytes are taken and all runs are back, then let the pipe drain
	task automatic settle();
		while (code_bytes_pending.size() != 0 || s_axis_tvalid || runs_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [12:0] pick_columns();
		case ($urandom_range(0, 19))
			0: return 13'd0;
			1: return 13'd4096;
			2: return 13'($urandom_range(4097, 8191));
			3: return 13'($urandom_range(17, 600));
			default: return 13'($urandom_range(1, 16));
		endcase
	endfunction

	function automatic logic [12:0] pick_rows();
		case ($urandom_range(0, 19))
			0: return 13'd0;
			1: return 13'($urandom_range(4097, 8191));
			2: return 13'd4096;
			3: return 13'($urandom_range(7, 100));
			default: return 13'($urandom_range(1, 6));
		endcase
	endfunction

	// pixel level, upper data bits random
	function automatic logic [12:0] pick_level();
		case ($urandom_range(0, 5))
			0: return {5'($urandom), 8'h00};
			1: return {5'($urandom), 8'hFF};
			default: return 13'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_phase();
		int n;
		int k;
		if ($urandom_range(0, 3) != 0) wr_reg(brle_pkg::REG_COLUMNS, pick_columns());
		if ($urandom_range(0, 3) != 0) wr_reg(brle_pkg::REG_ROWS, pick_rows());
		if ($urandom_range(0, 2) != 0) wr_reg(brle_pkg::REG_START_MODE, 13'($urandom));
		if ($urandom_range(0, 2) != 0) wr_reg(brle_pkg::REG_HIGH_VALUE, pick_level());
		if ($urandom_range(0, 2) != 0) wr_reg(brle_pkg::REG_LOW_VALUE, pick_level());
		tx_steady = ($urandom_range(0, 4) == 0);
		rx_steady = ($urandom_range(0, 4) == 0);
		n = $urandom_range(8, 40);
		@(posedge clk);
		for (k = 0; k < n; k++) code_bytes_pending.push_back(pick_byte());
		random_items += n;
		settle();
	endtask

	initial begin
		cfg_columns = brle_pkg::COLUMNS_RST;
		cfg_rows    = brle_pkg::ROWS_RST;
		cfg_mode    = brle_pkg::START_MODE_RST;
		cfg_high    = brle_pkg::HIGH_VALUE_RST;
		cfg_low     = brle_pkg::LOW_VALUE_RST;
		need_color  = 1'b1;
		cur_color   = 1'b0;
		cols_left   = int'(brle_pkg::COLUMNS_RST);
		code_left   = 0;
		code_val    = 0;
		row_count   = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset defaults; the first byte completes no run
		@(posedge clk);
		code_bytes_pending.push_back(8'h00);
		code_bytes_pending.push_back(8'hFF);
		code_bytes_pending.push_back(8'h7F);
		code_bytes_pending.push_back(8'h80);
		settle();

		// Fixed low start, short rows, overlong codes clipped
		wr_reg(brle_pkg::REG_COLUMNS, 13'd5);
		wr_reg(brle_pkg::REG_ROWS, 13'd3);
		wr_reg(brle_pkg::REG_START_MODE, {11'h7FF, MODE_START_LOW});
		wr_reg(brle_pkg::REG_HIGH_VALUE, 13'h00A5);
		wr_reg(brle_pkg::REG_LOW_VALUE, 13'h1F5A);
		rx_steady = 1'b0;
		@(posedge clk);
		code_bytes_pending.push_back(8'hFF);
		code_bytes_pending.push_back(8'h00);
		code_bytes_pending.push_back(8'h55);
		code_bytes_pending.push_back(8'hAA);
		settle();

		// Zero columns and rows act as one, mode three starts high, frame ends at once
		wr_reg(brle_pkg::REG_COLUMNS, 13'd0);
		wr_reg(brle_pkg::REG_ROWS, 13'd0);
		wr_reg(brle_pkg::REG_START_MODE, {11'd0, MODE_START_ALT});
		@(posedge clk);
		code_bytes_pending.push_back(8'hFF);
		code_bytes_pending.push_back(8'h00);
		settle();

		// Oversized columns and rows act as the maximum; inverted levels
		wr_reg(brle_pkg::REG_COLUMNS, 13'h1FFF);
		wr_reg(brle_pkg::REG_ROWS, 13'h1FFF);
		wr_reg(brle_pkg::REG_START_MODE, {11'd0, MODE_START_HIGH});
		wr_reg(brle_pkg::REG_HIGH_VALUE, 13'h1F00);
		wr_reg(brle_pkg::REG_LOW_VALUE, 13'h00FF);
		tx_steady = 1'b1;
		@(posedge clk);
		code_bytes_pending.push_back(8'hFF);
		code_bytes_pending.push_back(8'hFF);
		code_bytes_pending.push_back(8'hF0);
		code_bytes_pending.push_back(8'h00);
		settle();

		// One-pixel rows with color bits, then the row count is lowered below the rows done
		wr_reg(brle_pkg::REG_COLUMNS, 13'd1);
		wr_reg(brle_pkg::REG_ROWS, 13'd8);
		wr_reg(brle_pkg::REG_START_MODE, {11'd0, brle_pkg::MODE_COLOR_BIT});
		@(posedge clk);
		code_bytes_pending.push_back(8'h00);
		settle();
		wr_reg(brle_pkg::REG_ROWS, 13'd2);
		@(posedge clk);
		code_bytes_pending.push_back(8'hC3);
		settle();

		// Stop in the middle of a row, then change columns and mode for the next row
		wr_reg(brle_pkg::REG_COLUMNS, 13'd12);
		wr_reg(brle_pkg::REG_ROWS, 13'd4);
		@(posedge clk);
		code_bytes_pending.push_back(8'hC3);
		code_bytes_pending.push_back(8'h80);
		settle();
		wr_reg(brle_pkg::REG_COLUMNS, 13'd3);
		wr_reg(brle_pkg::REG_START_MODE, {11'd0, MODE_START_HIGH});
		tx_steady = 1'b0;
		@(posedge clk);
		code_bytes_pending.push_back(8'hFF);
		code_bytes_pending.push_back(8'h0F);
		code_bytes_pending.push_back(8'h3C);
		settle();

		while (random_items < RANDOM_ITEMS) random_phase();

		if (fail_count == 0 && runs_due.size() == 0) begin
			$display("PASS binary_rle_row_decoder_top");
		end else begin
			$display("FAIL binary_rle_row_decoder_top");
		end
		$finish;
	end

endmodule
